@@ hw/rtl/lbc_pkg.sv @@
// shared types and constants for the lru block buffer cache
package lbc_pkg;

	localparam int NUM_SLOTS_DEF = 32;
	localparam int CMD_W         = 2;
	localparam int DEV_W         = 8;
	localparam int BLK_W         = 32;
	localparam int SLOT_W        = 5;
	localparam int STAT_W        = 2;
	localparam int CNT_W         = 8;
	localparam int TAG_W         = DEV_W + BLK_W;

	localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

	typedef enum logic [CMD_W-1:0] {
		CMD_GET     = 2'd0,
		CMD_RELEASE = 2'd1,
		CMD_PIN     = 2'd2,
		CMD_UNPIN   = 2'd3
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_NOBUF = 2'd1,
		ST_UNDER = 2'd2,
		ST_OVER  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_COMMIT
	} state_t;

endpackage

@@ hw/rtl/lbc_req_if.sv @@
// request channel of the buffer cache
interface lbc_req_if
	import lbc_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  cmd;
	logic [DEV_W-1:0]  dev;
	logic [BLK_W-1:0]  blockno;
	logic [SLOT_W-1:0] slot;

	modport source (output valid, cmd, dev, blockno, slot, input ready);
	modport sink (input valid, cmd, dev, blockno, slot, output ready);
endinterface

@@ hw/rtl/lbc_rsp_if.sv @@
// result channel of the buffer cache
interface lbc_rsp_if
	import lbc_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [SLOT_W-1:0] slot_out;
	logic              hit;
	logic              needs_read;
	logic [STAT_W-1:0] status;

	modport source (output valid, slot_out, hit, needs_read, status, input ready);
	modport sink (input valid, slot_out, hit, needs_read, status, output ready);
endinterface

@@ hw/rtl/lru_block_buffer_cache_unit.sv @@
// lru buffer cache bookkeeping: tag scan, reference counts and recency ranks
// get: the tag memory is scanned one slot per cycle, then the scan drains and the
//   result is committed into the output register; no new request is taken until that commit
// release, pin, unpin: committed straight into the output register, with no scan
// a result waiting in the output register stalls only the next commit
// reset clears counts, valid and written bits and sets ranks at once; no clearing pass is needed
module lru_block_buffer_cache_unit
	import lbc_pkg::*;
#(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	lbc_req_if.sink   req,
	lbc_rsp_if.source rsp
);

	localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int SW = (IW > SLOT_W) ? IW : SLOT_W;
	localparam logic [IW-1:0] LAST_IDX = IW'(NUM_SLOTS - 1);
	localparam logic [SW:0]   NUM_EXT  = (SW + 1)'(NUM_SLOTS);

	state_t state_q, state_d;

	// latched request
	cmd_t              cmd_q;
	logic [DEV_W-1:0]  dev_q;
	logic [BLK_W-1:0]  blk_q;
	logic [SLOT_W-1:0] slot_q;

	// per-slot bookkeeping
	logic [CNT_W-1:0] count_q [NUM_SLOTS];
	logic [IW-1:0]    rank_q  [NUM_SLOTS];
	logic             valid_q [NUM_SLOTS];
	logic             wr_q    [NUM_SLOTS];

	// scan
	logic [IW-1:0]    idx_q;
	logic [IW-1:0]    idx_s1;
	logic             scan_s1;
	logic [TAG_W-1:0] tag_rd_s1;
	logic [TAG_W-1:0] tag_eff;
	logic             match;
	logic             hit_found_q, free_found_q;
	logic [IW-1:0]    hit_slot_q, hit_rank_q, free_slot_q, free_rank_q;

	// commit
	logic              accept, out_free, commit_go, scan_en;
	logic [SW-1:0]     slot_ext;
	logic              in_range;
	logic [IW-1:0]     sel;
	logic [CNT_W-1:0]  cnt_sel;
	logic              do_inc, do_dec, do_load, do_promote;
	logic [SLOT_W-1:0] res_slot;
	logic              res_hit, res_nr;
	status_t           res_st;

	// output register
	logic              rsp_valid_q;
	logic [SLOT_W-1:0] rsp_slot_q;
	logic              rsp_hit_q, rsp_nr_q;
	status_t           rsp_st_q;

	// tag memory
	lbc_tag_ram #(
		.DEPTH(NUM_SLOTS),
		.AW   (IW)
	) u_tag_ram (
		.clk  (clk),
		.we   (commit_go && do_load),
		.waddr(sel),
		.wdata({dev_q, blk_q}),
		.raddr(idx_q),
		.rdata(tag_rd_s1)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					state_d = (cmd_t'(req.cmd) == CMD_GET) ? S_SCAN : S_COMMIT;
				end
			end
			S_SCAN: begin
				if (idx_q == LAST_IDX) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: state_d = S_COMMIT;
			S_COMMIT: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		req.ready = (state_q == S_IDLE);
		scan_en   = (state_q == S_SCAN);
		out_free  = !rsp_valid_q || rsp.ready;
		commit_go = (state_q == S_COMMIT) && out_free;
	end

	assign accept = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// request latch
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= cmd_t'(req.cmd);
			dev_q  <= req.dev;
			blk_q  <= req.blockno;
			slot_q <= req.slot;
		end
	end

	// scan address counter and read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			scan_s1 <= 1'b0;
		end else begin
			scan_s1 <= scan_en;
			if (accept) begin
				idx_q <= '0;
			end else if (scan_en && idx_q != LAST_IDX) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= idx_q;
	end

	// a never-written tag reads as zero
	assign tag_eff = wr_q[idx_s1] ? tag_rd_s1 : '0;
	assign match   = (tag_eff == {dev_q, blk_q});

	// best hit: lowest rank; best free: highest rank with zero count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_found_q  <= 1'b0;
			free_found_q <= 1'b0;
		end else if (accept) begin
			hit_found_q  <= 1'b0;
			free_found_q <= 1'b0;
		end else if (scan_s1) begin
			if (match) begin
				hit_found_q <= 1'b1;
			end
			if (count_q[idx_s1] == '0) begin
				free_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (scan_s1) begin
			if (match && (!hit_found_q || rank_q[idx_s1] < hit_rank_q)) begin
				hit_slot_q <= idx_s1;
				hit_rank_q <= rank_q[idx_s1];
			end
			if (count_q[idx_s1] == '0 && (!free_found_q || rank_q[idx_s1] > free_rank_q)) begin
				free_slot_q <= idx_s1;
				free_rank_q <= rank_q[idx_s1];
			end
		end
	end

	// commit decision
	always_comb begin
		slot_ext   = SW'(slot_q);
		in_range   = {1'b0, slot_ext} < NUM_EXT;
		do_inc     = 1'b0;
		do_dec     = 1'b0;
		do_load    = 1'b0;
		do_promote = 1'b0;
		res_slot   = slot_q;
		res_hit    = 1'b0;
		res_nr     = 1'b0;
		res_st     = ST_OK;
		if (cmd_q == CMD_GET) begin
			sel = hit_found_q ? hit_slot_q : free_slot_q;
		end else begin
			sel = slot_ext[IW-1:0];
		end
		cnt_sel = count_q[sel];
		if (cmd_q == CMD_GET) begin
			priority if (hit_found_q) begin
				res_slot = SLOT_W'(sel);
				res_hit  = 1'b1;
				if (cnt_sel == COUNT_MAX) begin
					res_st = ST_OVER;
				end else begin
					do_inc = 1'b1;
					res_nr = !valid_q[sel];
				end
			end else if (free_found_q) begin
				res_slot = SLOT_W'(sel);
				do_load  = 1'b1;
				res_nr   = 1'b1;
			end else begin
				res_st = ST_NOBUF;
			end
		end else if (in_range) begin
			if (cmd_q == CMD_PIN) begin
				if (cnt_sel == COUNT_MAX) begin
					res_st = ST_OVER;
				end else begin
					do_inc = 1'b1;
				end
			end else if (cnt_sel == '0) begin
				res_st = ST_UNDER;
			end else begin
				do_dec     = 1'b1;
				do_promote = (cmd_q == CMD_RELEASE) && (cnt_sel == CNT_W'(1));
			end
		end
	end

	// per-slot state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				count_q[i] <= '0;
				valid_q[i] <= 1'b0;
				wr_q[i]    <= 1'b0;
				rank_q[i]  <= IW'(NUM_SLOTS - 1 - i);
			end
		end else if (commit_go) begin
			if (do_inc) begin
				count_q[sel] <= cnt_sel + 1'b1;
				// of the increments, only a get hit marks the slot valid; pin leaves it alone
				if (cmd_q == CMD_GET) begin
					valid_q[sel] <= 1'b1;
				end
			end
			if (do_dec) begin
				count_q[sel] <= cnt_sel - 1'b1;
			end
			if (do_load) begin
				count_q[sel] <= CNT_W'(1);
				valid_q[sel] <= 1'b1;
				wr_q[sel]    <= 1'b1;
			end
			if (do_promote) begin
				for (int i = 0; i < NUM_SLOTS; i++) begin
					if (IW'(i) == sel) begin
						rank_q[i] <= '0;
					end else if (rank_q[i] < rank_q[sel]) begin
						rank_q[i] <= rank_q[i] + 1'b1;
					end
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (commit_go) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit_go) begin
			rsp_slot_q <= res_slot;
			rsp_hit_q  <= res_hit;
			rsp_nr_q   <= res_nr;
			rsp_st_q   <= res_st;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.slot_out   = rsp_slot_q;
	assign rsp.hit        = rsp_hit_q;
	assign rsp.needs_read = rsp_nr_q;
	assign rsp.status     = rsp_st_q;

endmodule

@@ hw/rtl/lbc_tag_ram.sv @@
// tag memory: one write port, one registered read port
module lbc_tag_ram
	import lbc_pkg::*;
#(
	parameter int DEPTH = NUM_SLOTS_DEF,
	parameter int AW    = $clog2(NUM_SLOTS_DEF)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [TAG_W-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [TAG_W-1:0] rdata
);

	logic [TAG_W-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
